// File: design/queue_id_allocator_refcount_core_assert.svh
// assertion macros shared by the allocator rtl
// no dependencies; included by the top level
`ifndef QUEUE_ID_ALLOCATOR_REFCOUNT_CORE_ASSERT_SVH
`define QUEUE_ID_ALLOCATOR_REFCOUNT_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define QIDA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("qida assertion failed");

// next-cycle implication, disabled while in reset
`define QIDA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("qida assertion failed");

`endif

// File: design/qida_pkg.sv
// types and codes for the queue id allocator
// no dependencies; used by the interfaces and all modules
package qida_pkg;

  localparam int ADDR_W = 48;

  typedef logic [2:0]        kind_t;
  typedef logic [5:0]        qid_t;
  typedef logic [2:0]        status_t;
  typedef logic [7:0]        refcnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [6:0]        fcount_t;

  // request kinds
  localparam kind_t K_ALLOC = 3'd0;
  localparam kind_t K_REL   = 3'd1;
  localparam kind_t K_ADD   = 3'd2;
  localparam kind_t K_DROP  = 3'd3;
  localparam kind_t K_MAP   = 3'd4;
  localparam kind_t K_UNMAP = 3'd5;

  // result status codes
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_BAD_ID     = 3'd1;
  localparam status_t ST_NONE_FREE  = 3'd2;
  localparam status_t ST_REFERENCED = 3'd3;
  localparam status_t ST_NOT_ALLOC  = 3'd4;
  localparam status_t ST_LIMIT      = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic clear;
    logic accept;
    logic lookup;
    logic commit;
    logic finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

// File: design/qida_if.sv
// request and result channel interfaces, valid/ready handshake
// depends on qida_pkg
interface qida_req_if;
  import qida_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  qid_t  queue_id;
  modport source(output valid, kind, queue_id, input ready);
  modport sink(input valid, kind, queue_id, output ready);
endinterface

interface qida_rsp_if;
  import qida_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  qid_t    result_id;
  refcnt_t ref_count;
  addr_t   ring_address;
  fcount_t free_count;
  modport source(output valid, status, result_id, ref_count, ring_address, free_count,
                 input ready);
  modport sink(input valid, status, result_id, ref_count, ring_address, free_count,
               output ready);
endinterface

// File: design/qida_ctrl.sv
// controller state machine for the queue id allocator
// depends on qida_pkg
module qida_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qida_pkg::sts_t sts,
  output qida_pkg::cmd_t cmd
);
  import qida_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.clear  = (state_r == S_CLEAR);
    cmd.accept = (state_r == S_IDLE) && in_valid;
    cmd.lookup = (state_r == S_LOOK);
    cmd.commit = (state_r == S_UPD);
    cmd.finish = (state_r == S_FIN) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = S_UPD;
      S_UPD:   state_nxt = S_FIN;
      S_FIN:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/qida_dp.sv
// datapath: free stack, per-id table, ring address and result register
// depends on qida_pkg and qida_rsp_if
module qida_dp #(
  parameter int QUEUE_COUNT = 64,
  parameter int QUEUE_DEPTH = 1024,
  parameter int SLOT_BYTES  = 64,
  parameter int REF_BITS    = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  qida_pkg::addr_t   cfg_wr_data,
  input  qida_pkg::kind_t   in_kind,
  input  qida_pkg::qid_t    in_queue_id,
  input  qida_pkg::cmd_t    cmd,
  output qida_pkg::sts_t    sts,
  qida_rsp_if.source        out_rsp
);
  import qida_pkg::*;

  localparam int IDW = $clog2(QUEUE_COUNT);
  localparam int TW  = $clog2(QUEUE_COUNT + 1);
  localparam int EW  = REF_BITS + 2;
  localparam int unsigned STRIDE = QUEUE_DEPTH * SLOT_BYTES;
  localparam int SW  = $clog2(STRIDE + 1);
  localparam int PW  = IDW + SW;

  // table entry: {free, mapped, refs}
  logic [IDW-1:0] stk_mem [QUEUE_COUNT];
  logic [EW-1:0]  tbl_mem [QUEUE_COUNT];

  addr_t          base_r;
  kind_t          kind_r;
  qid_t           qid_r;
  logic [TW-1:0]  top_r, top_nxt;
  logic [TW-1:0]  hw_r, hw_nxt;
  logic [IDW-1:0] clr_r;
  logic [IDW-1:0] stk_q;
  logic           stk_hit_r;
  logic           bad_r, empty_r;
  logic [IDW-1:0] tgt, tgt_r;
  logic [EW-1:0]  tbl_q;
  status_t        st_r;
  logic [REF_BITS-1:0] rc_r;
  logic           mp_r, show_r;
  addr_t          off_r;
  logic           out_valid_r;

  // update decode
  logic                fr, mp;
  logic [REF_BITS-1:0] rc;
  status_t             st;
  logic                fr_n, mp_n;
  logic [REF_BITS-1:0] rc_n;
  logic                push, pop, show, tbl_we;

  assign sts.clear_last = cmd.clear && (clr_r == IDW'(QUEUE_COUNT - 1));
  assign sts.out_free   = !out_valid_r || out_rsp.ready;

  // allocate takes the top of the stack, untouched entries read as their own index
  assign tgt = (kind_r == K_ALLOC) ? (stk_hit_r ? stk_q : IDW'(top_r)) : IDW'(qid_r);

  assign fr = tbl_q[EW-1];
  assign mp = tbl_q[EW-2];
  assign rc = tbl_q[REF_BITS-1:0];

  always_comb begin
    st   = ST_OK;
    fr_n = fr;
    mp_n = mp;
    rc_n = rc;
    push = 1'b0;
    pop  = 1'b0;
    if (bad_r) begin
      st = ST_BAD_ID;
    end else if (kind_r == K_ALLOC) begin
      if (empty_r) begin
        st = ST_NONE_FREE;
      end else begin
        pop  = 1'b1;
        fr_n = 1'b0;
      end
    end else begin
      case (kind_r)
        K_REL: begin
          if (fr) begin
            st = ST_NOT_ALLOC;
          end else if (rc != '0) begin
            st = ST_REFERENCED;
          end else begin
            push = 1'b1;
            fr_n = 1'b1;
          end
        end
        K_ADD: begin
          if (rc == '1) st = ST_LIMIT;
          else rc_n = rc + 1'b1;
        end
        K_DROP: begin
          if (rc == '0) st = ST_LIMIT;
          else rc_n = rc - 1'b1;
        end
        K_MAP:   mp_n = 1'b1;
        K_UNMAP: mp_n = 1'b0;
        default: ;
      endcase
    end
    show   = !(bad_r || ((kind_r == K_ALLOC) && empty_r));
    tbl_we = cmd.commit && show;
  end

  always_comb begin
    top_nxt = top_r;
    hw_nxt  = hw_r;
    if (cmd.commit && pop) begin
      top_nxt = top_r + 1'b1;
      if (top_nxt > hw_r) hw_nxt = top_nxt;
    end else if (cmd.commit && push) begin
      top_nxt = top_r - 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.accept) stk_q <= stk_mem[IDW'(top_r)];
    if (cmd.commit && push) stk_mem[IDW'(top_r - 1'b1)] <= tgt_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) tbl_q <= tbl_mem[tgt];
    if (cmd.clear) begin
      tbl_mem[clr_r] <= {1'b1, 1'b0, {REF_BITS{1'b0}}};
    end else if (tbl_we) begin
      tbl_mem[tgt_r] <= {fr_n, mp_n, rc_n};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      top_r       <= '0;
      hw_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) base_r <= cfg_wr_data;
      top_r <= top_nxt;
      hw_r  <= hw_nxt;
      if (cmd.clear) clr_r <= clr_r + 1'b1;
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= in_kind;
      qid_r     <= in_queue_id;
      stk_hit_r <= top_r < hw_r;
      empty_r   <= top_r == TW'(QUEUE_COUNT);
      bad_r     <= (in_kind != K_ALLOC) && (int'(in_queue_id) >= QUEUE_COUNT);
    end
    if (cmd.lookup) tgt_r <= tgt;
    if (cmd.commit) begin
      st_r   <= st;
      rc_r   <= rc_n;
      mp_r   <= mp_n;
      show_r <= show;
      off_r  <= ADDR_W'(PW'(tgt_r) * PW'(STRIDE));
    end
    if (cmd.finish) begin
      out_rsp.status       <= st_r;
      out_rsp.result_id    <= bad_r ? qid_r : (show_r ? 6'(tgt_r) : '0);
      out_rsp.ref_count    <= show_r ? 8'(rc_r) : '0;
      out_rsp.ring_address <= (show_r && mp_r) ? base_r + off_r : '0;
      out_rsp.free_count   <= 7'(TW'(QUEUE_COUNT) - top_r);
    end
  end

  assign out_rsp.valid = out_valid_r;

endmodule

// File: design/queue_id_allocator_refcount_core.sv
// queue id allocator with per-id reference counts: one request in flight,
// stepped through stack read, table read, update and address add; a new
// request is taken only once the previous result is in the result register
// reset: synchronous active-low; afterwards a clearing pass over all QUEUE_COUNT
// entries initializes the per-id table while in_req.ready stays low;
// the queue_base register and config writes are live throughout
module queue_id_allocator_refcount_core #(
  parameter int QUEUE_COUNT = 64,
  parameter int QUEUE_DEPTH = 1024,
  parameter int SLOT_BYTES  = 64,
  parameter int REF_BITS    = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  qida_pkg::addr_t cfg_wr_data,
  qida_req_if.sink        in_req,
  qida_rsp_if.source      out_rsp
);
  import qida_pkg::*;

  `include "queue_id_allocator_refcount_core_assert.svh"

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // sequencer: clear pass, then accept -> lookup -> commit -> finish
  qida_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_req.ready = in_ready;

  // free stack (high-water mark stands in for its reset contents),
  // per-id free/mapped/refcount table, address math, result register
  qida_dp #(
    .QUEUE_COUNT (QUEUE_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SLOT_BYTES  (SLOT_BYTES),
    .REF_BITS    (REF_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_kind     (in_req.kind),
    .in_queue_id (in_req.queue_id),
    .cmd         (cmd),
    .sts         (sts),
    .out_rsp     (out_rsp)
  );

  // only one request in flight
  `QIDA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_req.valid && in_req.ready, !in_req.ready)

  // no request is taken while the table is being cleared
  `QIDA_ASSERT_NOW(a_no_req_in_clear, clk, rst_n, cmd.clear, !in_req.ready)

  // an empty-stack result carries no id state
  `QIDA_ASSERT_NOW(a_none_free_zero, clk, rst_n,
                   out_rsp.valid && (out_rsp.status == ST_NONE_FREE),
                   (out_rsp.ref_count == '0) && (out_rsp.ring_address == '0))

  // a bad-id result carries no id state
  `QIDA_ASSERT_NOW(a_bad_id_zero, clk, rst_n,
                   out_rsp.valid && (out_rsp.status == ST_BAD_ID),
                   (out_rsp.ref_count == '0) && (out_rsp.ring_address == '0))

endmodule
